// ----- rtl/lzm_pkg.sv -----
// shared constants, codes and the job record for the lazy zeroed linear memory
`default_nettype none
package lzm_pkg;

    localparam int unsigned BLOCK_BYTES    = 4096;
    localparam int unsigned PAGE_BYTES     = 65536;
    localparam int unsigned CAPACITY_PAGES = 16;

    localparam int unsigned TOTAL_BYTES = CAPACITY_PAGES * PAGE_BYTES;
    localparam int unsigned BLOCK_COUNT = (TOTAL_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
    localparam int unsigned ADDR_W      = $clog2(TOTAL_BYTES);
    localparam int unsigned OFF_W       = $clog2(BLOCK_BYTES);
    localparam int unsigned BLK_W       = ADDR_W - OFF_W;
    localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);

    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int unsigned PAGES_W = 5;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_GROW  = 2'd2;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_OOB     = 2'd1;
    localparam logic [1:0] STAT_REFUSED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_PAGES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT  = 4'd1;

    localparam logic [PAGES_W-1:0] CAP_PAGES = PAGES_W'(CAPACITY_PAGES);

    typedef struct packed {
        logic               access;
        logic               is_write;
        logic [ADDR_W-1:0]  addr;
        logic [1:0]         size;
        logic [63:0]        data;
        logic [1:0]         status;
        logic [PAGES_W-1:0] pages;
    } job_t;

endpackage
`default_nettype wire

// ----- rtl/lzm_intf.sv -----
// request, response and configuration channel interfaces
`default_nettype none
interface lzm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] address;
    logic [1:0]  access_size;
    logic [63:0] write_data;

    modport source (output valid, command, address, access_size, write_data, input ready);
    modport sink (input valid, command, address, access_size, write_data, output ready);
endinterface

interface lzm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [63:0]                 read_data;
    logic [1:0]                  status;
    logic [lzm_pkg::PAGES_W-1:0] pages_now;

    modport source (output valid, read_data, status, pages_now, input ready);
    modport sink (input valid, read_data, status, pages_now, output ready);
endinterface

interface lzm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lzm_pkg::CFG_IDX_W-1:0] index;
    logic [lzm_pkg::PAGES_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/lazy_zeroed_linear_memory.sv -----
// top level: byte-addressed linear memory with lazily zeroed blocks
// channels: req takes read, write and grow requests; rsp returns one beat per
//   request in order (read data, status, page count); cfg writes start_pages
//   (index 0) and page_limit (index 1), other indexes are ignored
// the front end checks bounds against the current size and settles grows at
//   once, so later requests see the new size; a two-entry queue feeds the
//   back end, which works on the 1 MiB byte memory one byte at a time
// steps from request beat to response beat:
//   grow, out-of-bounds and unused commands: from the queue straight out
//   read: per byte, a byte step and a wait for the registered read port
//   write: a byte step per byte, plus, for every block that the access
//     touches first, a step to spot it and a pass that clears all its bytes
// requests are taken while a response waits in the output register; once the
//   queue is full, req.ready drops until the back end frees an entry
// a stalled rsp holds its beat; the back end waits with the next result
// reset: start_pages 1, page_limit 0, no pages grown, every block absent;
//   no clearing pass is needed since absent blocks read as zero
// writing start_pages drops all blocks and grown pages in the same cycle
`default_nettype none
module lazy_zeroed_linear_memory (
    input  wire logic clk,
    input  wire logic rst_n,
    lzm_req_if.sink   req,
    lzm_rsp_if.source rsp,
    lzm_cfg_if.sink   cfg
);

    logic          push;
    lzm_pkg::job_t push_job;
    logic          fifo_full;
    logic          fifo_empty;
    logic          pop;
    lzm_pkg::job_t pop_job;
    logic          clear_presence;

    lzm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .cfg            (cfg),
        .fifo_full      (fifo_full),
        .push           (push),
        .push_job       (push_job),
        .clear_presence (clear_presence)
    );

    lzm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (fifo_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (fifo_empty)
    );

    lzm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .fifo_empty     (fifo_empty),
        .fifo_job       (pop_job),
        .pop            (pop),
        .clear_presence (clear_presence),
        .rsp            (rsp)
    );

endmodule
`default_nettype wire

// ----- rtl/lzm_front.sv -----
// front end: config registers, page accounting, bounds check and grow decision
`default_nettype none
module lzm_front (
    input  wire logic       clk,
    input  wire logic       rst_n,
    lzm_req_if.sink         req,
    lzm_cfg_if.sink         cfg,
    input  wire logic       fifo_full,
    output logic            push,
    output lzm_pkg::job_t   push_job,
    output logic            clear_presence
);

    logic [lzm_pkg::PAGES_W-1:0] start_reg, start_next;
    logic [lzm_pkg::PAGES_W-1:0] limit_reg, limit_next;
    logic [lzm_pkg::PAGES_W-1:0] grown_reg, grown_next;

    logic [lzm_pkg::PAGES_W-1:0] start_sat;
    logic [lzm_pkg::PAGES_W-1:0] cur_pages;
    logic [32:0]                 end_addr;
    logic [32:0]                 size_bytes;
    logic [3:0]                  nbytes;
    logic                        oob;
    logic                        room;
    logic                        allowed;
    logic                        grow_ok;

    assign req.ready = !fifo_full;
    assign cfg.ready = 1'b1;
    assign push      = req.valid && req.ready;

    assign clear_presence = cfg.valid && (cfg.index == lzm_pkg::CFG_START_PAGES);

    always_comb
    begin
        start_sat  = (start_reg > lzm_pkg::CAP_PAGES) ? lzm_pkg::CAP_PAGES : start_reg;
        cur_pages  = start_sat + grown_reg;
        nbytes     = 4'd1 << req.access_size;
        end_addr   = {1'b0, req.address} + 33'(nbytes);
        size_bytes = 33'(cur_pages) << lzm_pkg::PAGE_SHIFT;
        oob        = end_addr > size_bytes;
        room       = cur_pages < lzm_pkg::CAP_PAGES;
        allowed    = (limit_reg == '0) || (cur_pages < limit_reg);
        grow_ok    = room && allowed;

        push_job.access   = 1'b0;
        push_job.is_write = (req.command == lzm_pkg::CMD_WRITE);
        push_job.addr     = req.address[lzm_pkg::ADDR_W-1:0];
        push_job.size     = req.access_size;
        push_job.data     = req.write_data;
        push_job.status   = lzm_pkg::STAT_DONE;
        push_job.pages    = cur_pages;
        grown_next        = grown_reg;

        unique case (req.command)
            lzm_pkg::CMD_READ, lzm_pkg::CMD_WRITE:
            begin
                if (oob)
                begin
                    push_job.status = lzm_pkg::STAT_OOB;
                end
                else
                begin
                    push_job.access = 1'b1;
                end
            end
            lzm_pkg::CMD_GROW:
            begin
                if (grow_ok)
                begin
                    push_job.pages = cur_pages + 1'b1;
                    if (push)
                    begin
                        grown_next = grown_reg + 1'b1;
                    end
                end
                else
                begin
                    push_job.status = lzm_pkg::STAT_REFUSED;
                end
            end
            default:
            begin
                // unused command: plain done result
            end
        endcase

        start_next = start_reg;
        limit_next = limit_reg;
        if (cfg.valid)
        begin
            if (cfg.index == lzm_pkg::CFG_START_PAGES)
            begin
                start_next = cfg.data;
                grown_next = '0;
            end
            else if (cfg.index == lzm_pkg::CFG_PAGE_LIMIT)
            begin
                limit_next = cfg.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= lzm_pkg::PAGES_W'(1);
            limit_reg <= '0;
            grown_reg <= '0;
        end
        else
        begin
            start_reg <= start_next;
            limit_reg <= limit_next;
            grown_reg <= grown_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lzm_fifo.sv -----
// two-entry job queue between front and back end
`default_nettype none
module lzm_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lzm_pkg::job_t  push_job,
    output logic                full,
    input  wire logic           pop,
    output lzm_pkg::job_t       pop_job,
    output logic                empty
);

    lzm_pkg::job_t                   entries_reg [lzm_pkg::FIFO_DEPTH];
    logic [lzm_pkg::FIFO_PTR_W-1:0]  wptr_reg, wptr_next;
    logic [lzm_pkg::FIFO_PTR_W-1:0]  rptr_reg, rptr_next;
    logic [lzm_pkg::FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full    = (count_reg == lzm_pkg::FIFO_CNT_W'(lzm_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entries_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lzm_back.sv -----
// back end: byte memory, block presence bits, block clearing and result register
`default_nettype none
module lzm_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fifo_empty,
    input  wire lzm_pkg::job_t  fifo_job,
    output logic                pop,
    input  wire logic           clear_presence,
    lzm_rsp_if.source           rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BYTE  = 3'd1;
    localparam logic [2:0] S_RWAIT = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [7:0] mem_ram [lzm_pkg::TOTAL_BYTES];
    logic [7:0] mem_q;

    logic [2:0]                      state_reg, state_next;
    lzm_pkg::job_t                   job_reg, job_next;
    logic [2:0]                      cnt_reg, cnt_next;
    logic [63:0]                     acc_reg, acc_next;
    logic [lzm_pkg::OFF_W-1:0]       clr_off_reg, clr_off_next;
    logic                            rd_pres_reg, rd_pres_next;
    logic [lzm_pkg::BLOCK_COUNT-1:0] present_reg, present_next;

    logic                            out_valid_reg, out_valid_next;
    logic [63:0]                     out_data_reg, out_data_next;
    logic [1:0]                      out_status_reg, out_status_next;
    logic [lzm_pkg::PAGES_W-1:0]     out_pages_reg, out_pages_next;

    logic                            out_free;
    logic [lzm_pkg::ADDR_W-1:0]      cur_addr;
    logic [lzm_pkg::BLK_W-1:0]       cur_blk;
    logic [2:0]                      last_idx;
    logic [5:0]                      shamt;
    logic [7:0]                      cur_byte;
    logic                            mem_we;
    logic [lzm_pkg::ADDR_W-1:0]      mem_addr;
    logic [7:0]                      mem_wdata;

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.pages_now = out_pages_reg;

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        cur_addr = job_reg.addr + lzm_pkg::ADDR_W'(cnt_reg);
        cur_blk  = cur_addr[lzm_pkg::ADDR_W-1:lzm_pkg::OFF_W];
        shamt    = {cnt_reg, 3'b000};
        cur_byte = 8'(job_reg.data >> shamt);
        unique case (job_reg.size)
            2'd0:    last_idx = 3'd0;
            2'd1:    last_idx = 3'd1;
            2'd2:    last_idx = 3'd3;
            default: last_idx = 3'd7;
        endcase

        mem_addr  = (state_reg == S_CLEAR) ? {cur_blk, clr_off_reg} : cur_addr;
        mem_wdata = (state_reg == S_CLEAR) ? 8'd0 : cur_byte;
        mem_we    = (state_reg == S_CLEAR)
                    || ((state_reg == S_BYTE) && job_reg.is_write && present_reg[cur_blk]);
    end

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        clr_off_next    = clr_off_reg;
        rd_pres_next    = rd_pres_reg;
        present_next    = present_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_pages_next  = out_pages_reg;
        pop             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!fifo_empty)
                begin
                    if (fifo_job.access)
                    begin
                        pop        = 1'b1;
                        job_next   = fifo_job;
                        cnt_next   = '0;
                        acc_next   = '0;
                        state_next = S_BYTE;
                    end
                    else if (out_free)
                    begin
                        // no memory work: result goes straight out
                        pop             = 1'b1;
                        out_valid_next  = 1'b1;
                        out_data_next   = '0;
                        out_status_next = fifo_job.status;
                        out_pages_next  = fifo_job.pages;
                    end
                end
            end
            S_BYTE:
            begin
                if (job_reg.is_write)
                begin
                    if (!present_reg[cur_blk])
                    begin
                        clr_off_next = '0;
                        state_next   = S_CLEAR;
                    end
                    else if (cnt_reg == last_idx)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    rd_pres_next = present_reg[cur_blk];
                    state_next   = S_RWAIT;
                end
            end
            S_RWAIT:
            begin
                // absent block reads as zero
                if (rd_pres_reg)
                begin
                    acc_next = acc_reg | ({56'd0, mem_q} << shamt);
                end
                if (cnt_reg == last_idx)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_BYTE;
                end
            end
            S_CLEAR:
            begin
                clr_off_next = clr_off_reg + 1'b1;
                if (clr_off_reg == '1)
                begin
                    present_next[cur_blk] = 1'b1;
                    state_next            = S_BYTE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = acc_reg;
                    out_status_next = job_reg.status;
                    out_pages_next  = job_reg.pages;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (clear_presence)
        begin
            present_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        cnt_reg        <= cnt_next;
        acc_reg        <= acc_next;
        clr_off_reg    <= clr_off_next;
        rd_pres_reg    <= rd_pres_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_pages_reg  <= out_pages_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_ram[mem_addr] <= mem_wdata;
        end
        mem_q <= mem_ram[mem_addr];
    end

endmodule
`default_nettype wire

// ----- tb/lazy_zeroed_linear_memory_tb.sv -----
// self-checking testbench for the lazy zeroed linear memory: directed table, then random phases
`timescale 1ns / 1ps
module lazy_zeroed_linear_memory_tb;

    localparam logic [1:0]                    CMD_UNUSED  = 2'd3;
    localparam logic [lzm_pkg::CFG_IDX_W-1:0] CFG_IGNORED = 4'd9;
    localparam int                            STALL_LIMIT = 40000;
    localparam int                            RSP_HOLD    = 400;
    localparam int                            PHASES      = 8;
    localparam int                            PHASE_ITEMS = 238;
    localparam int                            HOT_BLOCKS  = 5;
    localparam logic [lzm_pkg::PAGES_W-1:0]   PHASE_START [PHASES] = '{1, 16, 0, 2, 31, 5, 0, 8};
    localparam logic [lzm_pkg::PAGES_W-1:0]   PHASE_LIMIT [PHASES] = '{0, 0, 0, 6, 31, 3, 16, 0};

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] address;
        logic [1:0]  access_size;
        logic [63:0] write_data;
    } mem_req_t;

    typedef struct packed {
        logic [63:0]                 read_data;
        logic [1:0]                  status;
        logic [lzm_pkg::PAGES_W-1:0] pages_now;
    } mem_rsp_t;

    typedef struct packed {
        row_kind_t                     kind;
        logic [lzm_pkg::CFG_IDX_W-1:0] cfg_index;
        logic [lzm_pkg::PAGES_W-1:0]   cfg_value;
        mem_req_t                      req;
        logic                          known;
        mem_rsp_t                      reply;
    } stim_row_t;

    logic clk;
    logic rst_n;

    lzm_req_if req_ch();
    lzm_rsp_if rsp_ch();
    lzm_cfg_if cfg_ch();

    lazy_zeroed_linear_memory u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // shadow of the memory contents and its registers
    bit [7:0]                      mem_image [lzm_pkg::TOTAL_BYTES];
    bit [lzm_pkg::BLOCK_COUNT-1:0] block_live;
    logic [lzm_pkg::PAGES_W-1:0]   grown_pages_q;
    logic [lzm_pkg::PAGES_W-1:0]   start_pages_q;
    logic [lzm_pkg::PAGES_W-1:0]   page_limit_q;

    mem_rsp_t owed_replies [$];

    bit idle_on;
    bit hold_rsp_req;
    int mismatches;
    int n_replies;
    int n_req, n_reads, n_writes, n_grows, n_oob, n_refused, n_fills, n_cfg;

    function automatic logic [lzm_pkg::PAGES_W-1:0] mem_pages();
        return ((start_pages_q > lzm_pkg::CAP_PAGES) ? lzm_pkg::CAP_PAGES : start_pages_q)
               + grown_pages_q;
    endfunction

    function automatic void linear_mem_set_reg(logic [lzm_pkg::CFG_IDX_W-1:0] idx,
                                               logic [lzm_pkg::PAGES_W-1:0] val);
        if (idx == lzm_pkg::CFG_START_PAGES)
        begin
            start_pages_q = val;
            block_live    = '0;
            grown_pages_q = '0;
        end
        else if (idx == lzm_pkg::CFG_PAGE_LIMIT)
        begin
            page_limit_q = val;
        end
    endfunction

    // applies one request to the shadow and returns the reply it should get
    function automatic mem_rsp_t linear_mem_access(mem_req_t r);
        mem_rsp_t                    o;
        logic [lzm_pkg::PAGES_W-1:0] pages;
        logic [63:0]                 span_end;
        int unsigned                 nbytes, i, k, a, b;
        o        = '0;
        pages    = mem_pages();
        nbytes   = 1 << r.access_size;
        span_end = {32'd0, r.address} + 64'(nbytes);
        n_req++;
        case (r.command)
            lzm_pkg::CMD_READ, lzm_pkg::CMD_WRITE:
            begin
                if (r.command == lzm_pkg::CMD_READ) n_reads++;
                else n_writes++;
                if (span_end > 64'(pages) * 64'(lzm_pkg::PAGE_BYTES))
                begin
                    o.status = lzm_pkg::STAT_OOB;
                    n_oob++;
                end
                else
                begin
                    for (i = 0; i < nbytes; i++)
                    begin
                        a = r.address + i;
                        b = a / lzm_pkg::BLOCK_BYTES;
                        if (r.command == lzm_pkg::CMD_READ)
                        begin
                            if (block_live[b]) o.read_data[8*i +: 8] = mem_image[a];
                        end
                        else
                        begin
                            // first touch of a block zeroes all of it
                            if (!block_live[b])
                            begin
                                for (k = 0; k < lzm_pkg::BLOCK_BYTES; k++)
                                    mem_image[b*lzm_pkg::BLOCK_BYTES + k] = 8'h00;
                                block_live[b] = 1'b1;
                                n_fills++;
                            end
                            mem_image[a] = r.write_data[8*i +: 8];
                        end
                    end
                end
            end
            lzm_pkg::CMD_GROW:
            begin
                n_grows++;
                if (pages < lzm_pkg::CAP_PAGES && (page_limit_q == '0 || pages < page_limit_q))
                begin
                    grown_pages_q++;
                    pages++;
                end
                else
                begin
                    o.status = lzm_pkg::STAT_REFUSED;
                    n_refused++;
                end
            end
            default: ;
        endcase
        o.pages_now = pages;
        return o;
    endfunction

    function automatic stim_row_t req_step(logic [1:0] cmd, logic [31:0] addr,
                                           logic [1:0] size, logic [63:0] data);
        stim_row_t s;
        s = '0;
        s.kind = ROW_REQ;
        s.req.command = cmd;
        s.req.address = addr;
        s.req.access_size = size;
        s.req.write_data = data;
        return s;
    endfunction

    function automatic stim_row_t req_step_known(logic [1:0] cmd, logic [31:0] addr,
                                                 logic [1:0] size, logic [63:0] data,
                                                 logic [63:0] rd, logic [1:0] st,
                                                 logic [lzm_pkg::PAGES_W-1:0] pg);
        stim_row_t s;
        s = req_step(cmd, addr, size, data);
        s.known = 1'b1;
        s.reply.read_data = rd;
        s.reply.status = st;
        s.reply.pages_now = pg;
        return s;
    endfunction

    function automatic stim_row_t cfg_step(logic [lzm_pkg::CFG_IDX_W-1:0] idx,
                                           logic [lzm_pkg::PAGES_W-1:0] val);
        stim_row_t s;
        s = '0;
        s.kind = ROW_CFG;
        s.cfg_index = idx;
        s.cfg_value = val;
        return s;
    endfunction

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_req(input mem_req_t r, input logic known, input mem_rsp_t typed);
        mem_rsp_t predicted;
        while (idle_on && $urandom_range(99) < 29)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= r.command;
        req_ch.address     <= r.address;
        req_ch.access_size <= r.access_size;
        req_ch.write_data  <= r.write_data;
        do @(posedge clk); while (!req_ch.ready);
        predicted = linear_mem_access(r);
        owed_replies.push_back(known ? typed : predicted);
        @(negedge clk);
    endtask

    // register writes only go out once every reply is back
    task automatic write_reg(input logic [lzm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lzm_pkg::PAGES_W-1:0] val);
        req_ch.valid <= 1'b0;
        while (owed_replies.size() != 0) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        linear_mem_set_reg(idx, val);
        n_cfg++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // reply side: random back-pressure plus one long hold-off on request
    initial
    begin : rsp_ready_drive
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp_req)
            begin
                hold_left    = RSP_HOLD;
                hold_rsp_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= !idle_on || ($urandom_range(99) >= 29);
            end
        end
    end

    always @(posedge clk)
    begin : rsp_check
        mem_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            n_replies++;
            if (owed_replies.size() == 0)
            begin
                if (mismatches < 10)
                    $display("reply %0d with none owed: data %h status %0d pages %0d",
                             n_replies, rsp_ch.read_data, rsp_ch.status, rsp_ch.pages_now);
                mismatches++;
            end
            else
            begin
                want = owed_replies.pop_front();
                if (rsp_ch.read_data !== want.read_data || rsp_ch.status !== want.status
                    || rsp_ch.pages_now !== want.pages_now)
                begin
                    if (mismatches < 10)
                        $display("reply %0d: data %h/%h status %0d/%0d pages %0d/%0d (exp/got)",
                                 n_replies, want.read_data, rsp_ch.read_data, want.status,
                                 rsp_ch.status, want.pages_now, rsp_ch.pages_now);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long without any beat on any channel
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("no beat for %0d cycles, %0d replies still owed",
                         quiet, owed_replies.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t   steps [$];
        mem_req_t    r;
        int unsigned hot [HOT_BLOCKS];
        int unsigned pick, off, ph, n, h;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.command     = lzm_pkg::CMD_READ;
        req_ch.address     = '0;
        req_ch.access_size = '0;
        req_ch.write_data  = '0;
        rsp_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = lzm_pkg::CFG_START_PAGES;
        cfg_ch.data        = '0;
        idle_on            = 1'b1;
        hold_rsp_req       = 1'b0;
        mismatches         = 0;
        n_replies          = 0;
        start_pages_q      = 5'd1;
        page_limit_q       = '0;
        grown_pages_q      = '0;
        block_live         = '0;

        // state after reset: one page, nothing present
        steps.push_back(req_step_known(lzm_pkg::CMD_READ, 32'h0, 2'd3, '0,
                                       '0, lzm_pkg::STAT_DONE, 5'd1));
        steps.push_back(req_step_known(lzm_pkg::CMD_READ, 32'h0000_FFFF, 2'd0, '0,
                                       '0, lzm_pkg::STAT_DONE, 5'd1));
        steps.push_back(req_step_known(lzm_pkg::CMD_READ, 32'h0000_FFFF, 2'd1, '0,
                                       '0, lzm_pkg::STAT_OOB, 5'd1));
        // no wrap of the address sum
        steps.push_back(req_step_known(lzm_pkg::CMD_READ, 32'hFFFF_FFF8, 2'd3, '0,
                                       '0, lzm_pkg::STAT_OOB, 5'd1));
        steps.push_back(req_step_known(lzm_pkg::CMD_WRITE, 32'hFFFF_FFFF, 2'd0, '1,
                                       '0, lzm_pkg::STAT_OOB, 5'd1));
        steps.push_back(req_step_known(lzm_pkg::CMD_WRITE, 32'h0, 2'd3, 64'h0123_4567_89AB_CDEF,
                                       '0, lzm_pkg::STAT_DONE, 5'd1));
        steps.push_back(req_step_known(lzm_pkg::CMD_READ, 32'h0, 2'd3, '0,
                                       64'h0123_4567_89AB_CDEF, lzm_pkg::STAT_DONE, 5'd1));
        steps.push_back(req_step(lzm_pkg::CMD_READ, 32'h4, 2'd2, '0));
        // access across a block boundary, second block fresh
        steps.push_back(req_step_known(lzm_pkg::CMD_WRITE, 32'h0FFE, 2'd2, '1,
                                       '0, lzm_pkg::STAT_DONE, 5'd1));
        steps.push_back(req_step(lzm_pkg::CMD_READ, 32'h0FFC, 2'd3, '0));
        steps.push_back(req_step_known(CMD_UNUSED, 32'h10, 2'd3, 64'h5555_AAAA_5555_AAAA,
                                       '0, lzm_pkg::STAT_DONE, 5'd1));
        steps.push_back(req_step(lzm_pkg::CMD_READ, 32'h10, 2'd0, '0));
        steps.push_back(req_step_known(lzm_pkg::CMD_GROW, '0, '0, '0,
                                       '0, lzm_pkg::STAT_DONE, 5'd2));
        steps.push_back(req_step_known(lzm_pkg::CMD_WRITE, 32'h0001_FFFF, 2'd0, 64'hA5,
                                       '0, lzm_pkg::STAT_DONE, 5'd2));
        steps.push_back(req_step_known(lzm_pkg::CMD_WRITE, 32'h0001_FFFF, 2'd1, '1,
                                       '0, lzm_pkg::STAT_OOB, 5'd2));
        steps.push_back(req_step(lzm_pkg::CMD_READ, 32'h0001_FFFF, 2'd0, '0));
        // start pages above capacity saturate; limit above capacity
        steps.push_back(cfg_step(lzm_pkg::CFG_START_PAGES, 5'd31));
        steps.push_back(cfg_step(lzm_pkg::CFG_PAGE_LIMIT, 5'd20));
        steps.push_back(req_step_known(lzm_pkg::CMD_GROW, '0, '0, '0,
                                       '0, lzm_pkg::STAT_REFUSED, 5'd16));
        steps.push_back(req_step_known(lzm_pkg::CMD_READ, 32'h000F_FFF8, 2'd3, '0,
                                       '0, lzm_pkg::STAT_DONE, 5'd16));
        steps.push_back(req_step_known(lzm_pkg::CMD_READ, 32'h0, 2'd3, '0,
                                       '0, lzm_pkg::STAT_DONE, 5'd16));
        steps.push_back(req_step_known(lzm_pkg::CMD_READ, 32'h0010_0000, 2'd0, '0,
                                       '0, lzm_pkg::STAT_OOB, 5'd16));
        // empty memory, then a limit of one page
        steps.push_back(cfg_step(lzm_pkg::CFG_START_PAGES, 5'd0));
        steps.push_back(cfg_step(lzm_pkg::CFG_PAGE_LIMIT, 5'd1));
        steps.push_back(cfg_step(CFG_IGNORED, 5'd3));
        steps.push_back(req_step_known(lzm_pkg::CMD_READ, 32'h0, 2'd0, '0,
                                       '0, lzm_pkg::STAT_OOB, 5'd0));
        steps.push_back(req_step_known(lzm_pkg::CMD_GROW, '0, '0, '0,
                                       '0, lzm_pkg::STAT_DONE, 5'd1));
        steps.push_back(req_step_known(lzm_pkg::CMD_GROW, '0, '0, '0,
                                       '0, lzm_pkg::STAT_REFUSED, 5'd1));
        // limit below the current size
        steps.push_back(cfg_step(lzm_pkg::CFG_START_PAGES, 5'd4));
        steps.push_back(cfg_step(lzm_pkg::CFG_PAGE_LIMIT, 5'd2));
        steps.push_back(req_step_known(lzm_pkg::CMD_GROW, '0, '0, '0,
                                       '0, lzm_pkg::STAT_REFUSED, 5'd4));
        steps.push_back(req_step_known(lzm_pkg::CMD_WRITE, 32'h0003_FFF8, 2'd3, '1,
                                       '0, lzm_pkg::STAT_DONE, 5'd4));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (steps[i])
        begin
            if (steps[i].kind == ROW_CFG)
                write_reg(steps[i].cfg_index, steps[i].cfg_value);
            else
                send_req(steps[i].req, steps[i].known, steps[i].reply);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            write_reg(lzm_pkg::CFG_START_PAGES, PHASE_START[ph]);
            write_reg(lzm_pkg::CFG_PAGE_LIMIT, PHASE_LIMIT[ph]);
            // a few hot blocks per phase keep first-write clears rare
            hot[0] = 0;
            for (h = 1; h < HOT_BLOCKS; h++) hot[h] = $urandom_range(lzm_pkg::BLOCK_COUNT - 1);
            idle_on = (ph != 3);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 1 && n == 100) hold_rsp_req = 1'b1;
                pick = $urandom_range(99);
                r.command = (pick < 42) ? lzm_pkg::CMD_READ : (pick < 84) ? lzm_pkg::CMD_WRITE :
                            (pick < 95) ? lzm_pkg::CMD_GROW : CMD_UNUSED;
                r.access_size = $urandom_range(3);
                r.write_data  = {$urandom, $urandom};
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    pick = $urandom_range(99);
                    if (pick < 50)
                        off = $urandom_range(63);
                    else if (pick < 75)
                        off = $urandom_range(lzm_pkg::BLOCK_BYTES - 8, lzm_pkg::BLOCK_BYTES - 1);
                    else
                        off = $urandom_range(lzm_pkg::BLOCK_BYTES - 1);
                    r.address = 32'(hot[$urandom_range(HOT_BLOCKS - 1)] * lzm_pkg::BLOCK_BYTES
                                    + off);
                end
                else if (pick < 88)
                begin
                    // right at the end of the current size
                    r.address = 32'(mem_pages()) * lzm_pkg::PAGE_BYTES - $urandom_range(1, 9);
                end
                else
                begin
                    r.address = $urandom;
                end
                send_req(r, 1'b0, '0);
            end
        end

        req_ch.valid <= 1'b0;
        while (owed_replies.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);

        $display("covered %0d requests (%0d reads, %0d writes, %0d grows), %0d register writes",
                 n_req, n_reads, n_writes, n_grows, n_cfg);
        $display("%0d out of bounds, %0d grows refused, %0d blocks cleared, %0d bad replies",
                 n_oob, n_refused, n_fills, mismatches);
        if (mismatches == 0 && owed_replies.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lzm_pkg.sv
rtl/lzm_intf.sv
rtl/lzm_front.sv
rtl/lzm_fifo.sv
rtl/lzm_back.sv
rtl/lazy_zeroed_linear_memory.sv
tb/lazy_zeroed_linear_memory_tb.sv
